// ===== design/jsc_pkg.sv =====
// shared constants and types for the token structure checker
`default_nettype none

package jsc_pkg;

  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] DASH_CHAR = 8'h2D;
  localparam logic [7:0] UNDERSCORE_CHAR = 8'h5F;

  localparam logic [5:0] LOWER_BASE = 6'd26;
  localparam logic [5:0] DIGIT_BASE = 6'd52;
  localparam logic [5:0] DASH_VALUE = 6'd62;
  localparam logic [5:0] UNDERSCORE_VALUE = 6'd63;

  localparam logic [1:0] SEG_HEADER = 2'd0;
  localparam logic [1:0] SEG_PAYLOAD = 2'd1;
  localparam logic [1:0] SEG_SIGNATURE = 2'd2;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } sextet_t;

endpackage

`default_nettype wire

// ===== design/jsc_in_if.sv =====
// character channel into the checker
`default_nettype none

interface jsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

`default_nettype wire

// ===== design/jsc_out_if.sv =====
// result channel out of the checker
`default_nettype none

interface jsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic       token_done;
  logic       verdict;

  modport source (output valid, output payload_byte, output byte_valid,
                  output token_done, output verdict, input ready);
  modport sink (input valid, input payload_byte, input byte_valid,
                input token_done, input verdict, output ready);
endinterface

`default_nettype wire

// ===== design/jwt_structure_check_b64url_decode.sv =====
// Compact token structure checker with on-the-fly decoding of the middle segment.
// One character enters per clock cycle while the input is ready; each character's result is
// registered in the single result register until the receiver takes it, and the input
// stays ready whenever the result register is empty or being drained. Every
// character returns one result: a decoded payload byte when it completed one, and on the
// character marked last the verdict (0 well formed, 1 malformed). The checker then returns
// to its reset state for the next token. Bytes are emitted even after a fault; downstream
// drops them when the verdict is malformed.
`default_nettype none

module jwt_structure_check_b64url_decode (
  input  wire logic  clk,
  input  wire logic  rst_n,
  jsc_in_if.sink     in_ch,
  jsc_out_if.source  out_ch
);

  logic [1:0]  seg_r, seg_nxt;
  logic [1:0]  len_r, len_nxt;
  logic        nonempty_r, nonempty_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [2:0]  bits_r, bits_nxt;
  logic        bad_r, bad_nxt;

  logic        out_valid_r;
  logic [7:0]  byte_r, byte_nxt;
  logic        byte_valid_r, byte_valid_nxt;
  logic        done_r, done_nxt;
  logic        verdict_r, verdict_nxt;

  logic             accept;
  jsc_pkg::sextet_t sextet;

  jsc_sextet u_sextet (
    .symbol (in_ch.symbol),
    .sextet (sextet)
  );

  // a segment may not close empty, with length 1 mod 4, or with leftover payload bits set
  function automatic logic close_bad(input logic [1:0] seg, input logic [1:0] len,
                                     input logic nonempty, input logic [11:0] acc,
                                     input logic [2:0] bits);
    logic [11:0] mask;
    logic        fault;
    mask  = (12'd1 << bits) - 12'd1;
    fault = !nonempty || (len == 2'd1);
    if (seg == jsc_pkg::SEG_PAYLOAD && (acc & mask) != 12'd0) begin
      fault = 1'b1;
    end
    return fault;
  endfunction

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    logic [3:0] sum;
    seg_nxt        = seg_r;
    len_nxt        = len_r;
    nonempty_nxt   = nonempty_r;
    acc_nxt        = acc_r;
    bits_nxt       = bits_r;
    bad_nxt        = bad_r;
    byte_nxt       = 8'd0;
    byte_valid_nxt = 1'b0;
    done_nxt       = 1'b0;
    verdict_nxt    = 1'b0;
    sum            = 4'd0;

    if (in_ch.symbol == jsc_pkg::DOT_CHAR) begin
      if (close_bad(seg_r, len_r, nonempty_r, acc_r, bits_r)) begin
        bad_nxt = 1'b1;
      end
      if (seg_r == jsc_pkg::SEG_SIGNATURE) begin
        bad_nxt = 1'b1;
      end else begin
        seg_nxt = seg_r + 2'd1;
      end
      len_nxt      = 2'd0;
      nonempty_nxt = 1'b0;
      acc_nxt      = 12'd0;
      bits_nxt     = 3'd0;
    end else begin
      len_nxt      = len_r + 2'd1;
      nonempty_nxt = 1'b1;
      if (!sextet.ok) begin
        bad_nxt = 1'b1;
      end else if (seg_r == jsc_pkg::SEG_PAYLOAD) begin
        acc_nxt = {acc_r[5:0], sextet.value};
        sum     = {1'b0, bits_r} + 4'd6;
        if (sum >= 4'd8) begin
          bits_nxt       = 3'(sum - 4'd8);
          byte_nxt       = 8'(acc_nxt >> bits_nxt);
          byte_valid_nxt = 1'b1;
          if (byte_nxt == 8'd0) begin
            bad_nxt = 1'b1;
          end
        end else begin
          bits_nxt = 3'(sum);
        end
      end
    end

    if (in_ch.last_symbol) begin
      if (close_bad(seg_nxt, len_nxt, nonempty_nxt, acc_nxt, bits_nxt) ||
          seg_nxt != jsc_pkg::SEG_SIGNATURE) begin
        bad_nxt = 1'b1;
      end
      done_nxt     = 1'b1;
      verdict_nxt  = bad_nxt;
      seg_nxt      = jsc_pkg::SEG_HEADER;
      len_nxt      = 2'd0;
      nonempty_nxt = 1'b0;
      acc_nxt      = 12'd0;
      bits_nxt     = 3'd0;
      bad_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= jsc_pkg::SEG_HEADER;
      len_r       <= 2'd0;
      nonempty_r  <= 1'b0;
      acc_r       <= 12'd0;
      bits_r      <= 3'd0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        seg_r      <= seg_nxt;
        len_r      <= len_nxt;
        nonempty_r <= nonempty_nxt;
        acc_r      <= acc_nxt;
        bits_r     <= bits_nxt;
        bad_r      <= bad_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r       <= byte_nxt;
      byte_valid_r <= byte_valid_nxt;
      done_r       <= done_nxt;
      verdict_r    <= verdict_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.payload_byte = byte_r;
  assign out_ch.byte_valid   = byte_valid_r;
  assign out_ch.token_done   = done_r;
  assign out_ch.verdict      = verdict_r;

  // the decoder only ever holds an even count of leftover bits below a byte
  a_bits_even: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r == 3'd0 || bits_r == 3'd2 || bits_r == 3'd4 || bits_r == 3'd6)
    else $error("leftover bit count out of range");

  // a last character puts the segment state back to its start
  a_token_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.last_symbol |=> seg_r == jsc_pkg::SEG_HEADER && bits_r == 3'd0 &&
      !bad_r && !nonempty_r)
    else $error("state not cleared after token end");

  // a malformed verdict is only ever reported with token end
  a_verdict_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && verdict_r |-> done_r)
    else $error("verdict raised without token end");

  // decoded bytes only come from the payload segment
  a_byte_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    accept && byte_valid_nxt |-> seg_r == jsc_pkg::SEG_PAYLOAD)
    else $error("byte decoded outside payload segment");

endmodule

`default_nettype wire

// ===== design/jsc_sextet.sv =====
// base64url character to 6-bit value lookup
`default_nettype none

module jsc_sextet (
  input  wire logic [7:0]      symbol,
  output jsc_pkg::sextet_t     sextet
);

  always_comb begin
    sextet = '0;
    if (symbol >= 8'h41 && symbol <= 8'h5A) begin
      sextet.ok    = 1'b1;
      sextet.value = 6'(symbol - 8'h41);
    end else if (symbol >= 8'h61 && symbol <= 8'h7A) begin
      sextet.ok    = 1'b1;
      sextet.value = 6'(symbol - 8'h61) + jsc_pkg::LOWER_BASE;
    end else if (symbol >= 8'h30 && symbol <= 8'h39) begin
      sextet.ok    = 1'b1;
      sextet.value = 6'(symbol - 8'h30) + jsc_pkg::DIGIT_BASE;
    end else if (symbol == jsc_pkg::DASH_CHAR) begin
      sextet.ok    = 1'b1;
      sextet.value = jsc_pkg::DASH_VALUE;
    end else if (symbol == jsc_pkg::UNDERSCORE_CHAR) begin
      sextet.ok    = 1'b1;
      sextet.value = jsc_pkg::UNDERSCORE_VALUE;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the token structure checker: directed, random and back-pressure tests
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       token_done;
    logic       verdict;
  } char_result_t;

  typedef enum int {
    FLT_BAD_CHAR,
    FLT_EXTRA_DOT,
    FLT_DROP_CHAR,
    FLT_CUT_SHORT,
    FLT_TRAILING_DOT,
    FLT_BIT_FLIP
  } fault_kind_t;

  logic clk;
  logic rst_n;

  jsc_in_if  in_ch ();
  jsc_out_if out_ch ();

  jwt_structure_check_b64url_decode i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // checker state mirrored in the testbench
  logic [1:0]  seg_idx;
  logic [1:0]  seg_len_mod4;
  logic        seg_has_chars;
  logic [11:0] acc_bits;
  logic [3:0]  acc_count;
  logic        token_bad;

  char_result_t expected_q[$];
  int           items_sent;
  int           mismatches;
  int           cycle_count;
  int           burst_left;
  bit           no_gaps;
  bit           hold_off_req;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic jsc_pkg::sextet_t lookup_sextet(logic [7:0] c);
    jsc_pkg::sextet_t sx;
    sx.ok = 1'b1;
    sx.value = '0;
    if (c >= "A" && c <= "Z") begin
      sx.value = 6'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      sx.value = 6'(c - "a") + jsc_pkg::LOWER_BASE;
    end else if (c >= "0" && c <= "9") begin
      sx.value = 6'(c - "0") + jsc_pkg::DIGIT_BASE;
    end else if (c == jsc_pkg::DASH_CHAR) begin
      sx.value = jsc_pkg::DASH_VALUE;
    end else if (c == jsc_pkg::UNDERSCORE_CHAR) begin
      sx.value = jsc_pkg::UNDERSCORE_VALUE;
    end else begin
      sx.ok = 1'b0;
    end
    return sx;
  endfunction

  function automatic logic [7:0] char_of_sextet(logic [5:0] v);
    if (v < jsc_pkg::LOWER_BASE) return 8'("A") + 8'(v);
    if (v < jsc_pkg::DIGIT_BASE) return 8'("a") + 8'(v - jsc_pkg::LOWER_BASE);
    if (v < jsc_pkg::DASH_VALUE) return 8'("0") + 8'(v - jsc_pkg::DIGIT_BASE);
    if (v == jsc_pkg::DASH_VALUE) return jsc_pkg::DASH_CHAR;
    return jsc_pkg::UNDERSCORE_CHAR;
  endfunction

  function automatic void clear_segment();
    seg_len_mod4 = '0;
    seg_has_chars = 1'b0;
    acc_bits = '0;
    acc_count = '0;
  endfunction

  function automatic void reset_checker_state();
    seg_idx = jsc_pkg::SEG_HEADER;
    clear_segment();
    token_bad = 1'b0;
  endfunction

  function automatic void check_segment_close();
    if (!seg_has_chars || seg_len_mod4 == 2'd1) token_bad = 1'b1;
    // leftover payload bits must be zero
    if (seg_idx == jsc_pkg::SEG_PAYLOAD && acc_count != 0) begin
      if ((acc_bits & ((12'd1 << acc_count) - 12'd1)) != 0) token_bad = 1'b1;
    end
  endfunction

  function automatic char_result_t predict_char_result(logic [7:0] sym, logic last);
    char_result_t     r;
    jsc_pkg::sextet_t sx;
    r = '0;
    if (sym == jsc_pkg::DOT_CHAR) begin
      check_segment_close();
      if (seg_idx >= jsc_pkg::SEG_SIGNATURE) begin
        token_bad = 1'b1;
        seg_idx = jsc_pkg::SEG_SIGNATURE;
      end else begin
        seg_idx = seg_idx + 2'd1;
      end
      clear_segment();
    end else begin
      sx = lookup_sextet(sym);
      seg_len_mod4 = seg_len_mod4 + 2'd1;
      seg_has_chars = 1'b1;
      if (!sx.ok) begin
        token_bad = 1'b1;
      end else if (seg_idx == jsc_pkg::SEG_PAYLOAD) begin
        acc_bits = {acc_bits[5:0], sx.value};
        acc_count = acc_count + 4'd6;
        if (acc_count >= 4'd8) begin
          acc_count = acc_count - 4'd8;
          r.payload_byte = 8'(acc_bits >> acc_count);
          r.byte_valid = 1'b1;
          if (r.payload_byte == 8'h00) token_bad = 1'b1;
        end
      end
    end
    if (last) begin
      check_segment_close();
      if (seg_idx != jsc_pkg::SEG_SIGNATURE) token_bad = 1'b1;
      r.token_done = 1'b1;
      r.verdict = token_bad;
      reset_checker_state();
    end
    return r;
  endfunction

  // one item per call, sender idles between bursts unless gaps are switched off
  task automatic send_symbol(input logic [7:0] sym, input logic last);
    if (burst_left == 0) begin
      if (!no_gaps) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.symbol <= sym;
    in_ch.last_symbol <= last;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(predict_char_result(sym, last));
    items_sent++;
  endtask

  task automatic send_token(ref char_q_t tok);
    for (int i = 0; i < tok.size(); i++) send_symbol(tok[i], i == tok.size() - 1);
  endtask

  task automatic append_text(ref char_q_t tok, input string s);
    for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
  endtask

  // random bytes encoded without padding, so the length is never 1 mod 4
  task automatic append_encoded(ref char_q_t tok, input int nbytes, input bit no_zero);
    logic [23:0] grp;
    int          i;
    int          take;
    i = 0;
    while (i < nbytes) begin
      take = (nbytes - i >= 3) ? 3 : nbytes - i;
      grp = '0;
      for (int k = 0; k < take; k++)
        grp[23 - 8*k -: 8] = 8'($urandom_range(no_zero ? 1 : 0, 255));
      for (int k = 0; k <= take; k++) tok.push_back(char_of_sextet(grp[23 - 6*k -: 6]));
      i += take;
    end
  endtask

  task automatic make_good_token(ref char_q_t tok, input bit no_zero);
    int payload_len;
    payload_len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    tok.delete();
    append_encoded(tok, $urandom_range(1, 6), 1'b0);
    tok.push_back(jsc_pkg::DOT_CHAR);
    append_encoded(tok, payload_len, no_zero);
    tok.push_back(jsc_pkg::DOT_CHAR);
    append_encoded(tok, $urandom_range(1, 8), 1'b0);
  endtask

  task automatic test_directed();
    char_q_t tok;
    // well formed, payload decodes to one byte
    tok.delete();
    append_text(tok, "ab.QQ.cd");
    send_token(tok);
    // zero byte in payload, short header, token ends early
    tok.delete();
    append_text(tok, "A.AA");
    send_token(tok);
    // empty segments, third dot, dot as last character
    tok.delete();
    append_text(tok, "...");
    send_token(tok);
    // characters outside the alphabet at the byte extremes
    tok = {8'hFF, jsc_pkg::DOT_CHAR, 8'h00, jsc_pkg::DOT_CHAR, 8'h7F};
    send_token(tok);
    // non-zero leftover bits in payload
    tok.delete();
    append_text(tok, "ab.QR.cd");
    send_token(tok);
  endtask

  task automatic test_well_formed(input int n_items);
    char_q_t tok;
    int      target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      make_good_token(tok, 1'b1);
      send_token(tok);
    end
  endtask

  task automatic test_faulty_tokens(input int n_items);
    char_q_t     tok;
    int          target;
    int          pos;
    fault_kind_t kind;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) < 7) begin
        make_good_token(tok, 1'($urandom_range(0, 1)));
        pos = $urandom_range(0, tok.size() - 1);
        kind = fault_kind_t'($urandom_range(0, 5));
        case (kind)
          FLT_BAD_CHAR: begin
            tok[pos] = 8'($urandom_range(0, 255));
          end
          FLT_EXTRA_DOT: begin
            tok.insert(pos, jsc_pkg::DOT_CHAR);
          end
          FLT_DROP_CHAR: begin
            if (tok.size() > 1) tok.delete(pos);
          end
          FLT_CUT_SHORT: begin
            while (tok.size() > pos + 1) void'(tok.pop_back());
          end
          FLT_TRAILING_DOT: begin
            tok.push_back(jsc_pkg::DOT_CHAR);
          end
          default: begin
            tok[pos] = tok[pos] ^ (8'h01 << $urandom_range(0, 7));
          end
        endcase
      end else begin
        // noise: dots, arbitrary bytes and alphabet characters
        tok.delete();
        repeat ($urandom_range(1, 10)) begin
          case ($urandom_range(0, 3))
            0: tok.push_back(jsc_pkg::DOT_CHAR);
            1: tok.push_back(8'($urandom_range(0, 255)));
            default: tok.push_back(char_of_sextet(6'($urandom_range(0, 63))));
          endcase
        end
      end
      send_token(tok);
    end
  endtask

  // receiver holds off while the sender keeps offering items back to back
  task automatic test_output_hold_off(input int n_items);
    char_q_t tok;
    int      target;
    target = items_sent + n_items;
    no_gaps = 1'b1;
    hold_off_req = 1'b1;
    while (items_sent < target) begin
      make_good_token(tok, $urandom_range(0, 3) != 0);
      send_token(tok);
    end
    no_gaps = 1'b0;
  endtask

  // receiver stall pattern, switching mode every so often
  initial begin : receiver
    int mode;
    int mode_left;
    int period;
    int phase;
    int hold_left;
    mode = 0;
    mode_left = 0;
    period = 2;
    phase = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && hold_left == 0) hold_left = HOLD_OFF_CYCLES;
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        period = $urandom_range(2, 5);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) hold_off_req = 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= (phase % period) != 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    char_result_t got;
    char_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.payload_byte = out_ch.payload_byte;
      got.byte_valid = out_ch.byte_valid;
      got.token_done = out_ch.token_done;
      got.verdict = out_ch.verdict;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with none expected: byte %02h valid %b done %b verdict %b",
                   got.payload_byte, got.byte_valid, got.token_done, got.verdict);
      end else begin
        want = expected_q.pop_front();
        if (got.payload_byte !== want.payload_byte || got.byte_valid !== want.byte_valid ||
            got.token_done !== want.token_done || got.verdict !== want.verdict) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp byte %02h valid %b done %b verdict %b",
                      " / got byte %02h valid %b done %b verdict %b"},
                     want.payload_byte, want.byte_valid, want.token_done, want.verdict,
                     got.payload_byte, got.byte_valid, got.token_done, got.verdict);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    items_sent = 0;
    mismatches = 0;
    cycle_count = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    hold_off_req = 1'b0;
    reset_checker_state();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.symbol <= '0;
    in_ch.last_symbol <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_well_formed(300);
    test_faulty_tokens(380);
    test_output_hold_off(150);

    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
